/* design/tpzr_pkg.sv */
// Shared types and constants of the torus point z-buffer raster unit.
package tpzr_pkg;

  localparam int MaxWidth   = 128;
  localparam int MaxHeight  = 64;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int AddrW      = ColW + RowW;
  localparam int DepthCells = MaxWidth * MaxHeight;
  localparam int DepthW     = 17;

  localparam logic [DepthW-1:0] DepthMax = '1;
  localparam logic signed [23:0] ZBias   = 24'sd262144;
  localparam logic signed [23:0] OozSatZ = 24'sd131072;
  localparam logic signed [23:0] RingRad = 24'sd32768;
  localparam logic [7:0] WidthMargin     = 8'd30;
  localparam logic [7:0] WidthSplit      = 8'd50;
  localparam logic [3:0] GlyphMax        = 4'd11;
  localparam logic [4:0] NumMulSteps     = 5'd24;
  localparam logic [4:0] NumProjSteps    = 5'd6;
  localparam logic [4:0] CellDivSteps    = 5'd7;
  localparam logic [4:0] DepthDivSteps   = 5'd17;
  localparam logic [21:0] DepthDividend  = 22'd131072;

  localparam logic RegScreenWidth  = 1'b0;
  localparam logic RegScreenHeight = 1'b1;

  typedef struct packed {
    logic               new_frame;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_b;
    logic signed [15:0] sin_b;
    logic signed [15:0] cos_tube;
    logic signed [15:0] sin_tube;
    logic signed [15:0] cos_ring;
    logic signed [15:0] sin_ring;
  } sample_t;

  typedef struct packed {
    logic [6:0] column;
    logic [5:0] row;
    logic [3:0] glyph;
  } result_t;

  typedef struct packed {
    logic              ok;
    logic [ColW-1:0]   column;
    logic [RowW-1:0]   row;
    logic [3:0]        glyph;
    logic [DepthW-1:0] ooz;
  } hit_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_MUL, PH_SUM, PH_PROJ, PH_DIVX, PH_DIVY, PH_DIVZ, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_BUSY, ST_READ, ST_CHECK
  } state_e;

endpackage

/* design/tpzr_if.sv */
// Valid/ready channel interfaces for samples and plotted cells.
interface tpzr_in_if;
  logic              valid;
  logic              ready;
  tpzr_pkg::sample_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tpzr_out_if;
  logic              valid;
  logic              ready;
  tpzr_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/tpzr_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module tpzr_ram #(
  parameter int Depth = 8192,
  parameter int Width = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

/* design/tpzr_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module tpzr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [21:0] rem_i,
  input  logic [16:0] bits_i,
  input  logic [4:0]  steps_i,
  input  logic [21:0] divisor_i,
  output logic        done_o,
  output logic [16:0] quot_o
);
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [21:0] rem_q;
  logic [16:0] bits_q, quot_q;
  logic [22:0] shifted;
  logic [23:0] trial;

  assign shifted = {rem_q, bits_q[16]};
  assign trial   = {1'b0, shifted} - {2'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      bits_q <= bits_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= trial[23] ? shifted[21:0] : trial[21:0];
      bits_q <= {bits_q[15:0], 1'b0};
      quot_q <= {quot_q[15:0], ~trial[23]};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

/* design/tpzr_geom.sv */
// Sequenced rotation, projection and reciprocal depth over one shared multiplier.
module tpzr_geom (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tpzr_pkg::sample_t sample_i,
  input  logic [7:0]        dw_i,
  input  logic [6:0]        h_i,
  output logic              done_o,
  output tpzr_pkg::hit_t    hit_o
);
  tpzr_pkg::phase_e   phase_q;
  logic [4:0]         step_q;
  tpzr_pkg::sample_t  smp_q;
  logic signed [25:0] t_q [24];
  logic signed [23:0] x_q, y_q, z_q, l_q;
  logic signed [31:0] r_q [6];
  logic [6:0]         qx_q;
  logic [5:0]         qy_q;
  logic [16:0]        ooz_q;

  logic signed [23:0] op_a, op_b, cx, cy, ca, sa, cb, sb, ct, st, cp, sp;
  logic signed [47:0] prod;
  logic signed [32:0] numx, numy;
  logic signed [33:0] negx, negy;
  logic               div_start, div_done;
  logic [21:0]        div_rem;
  logic [16:0]        div_bits, div_quot;
  logic [4:0]         div_steps;
  logic               vx, vy;

  assign ca = 24'(smp_q.cos_a);
  assign sa = 24'(smp_q.sin_a);
  assign cb = 24'(smp_q.cos_b);
  assign sb = 24'(smp_q.sin_b);
  assign ct = 24'(smp_q.cos_tube);
  assign st = 24'(smp_q.sin_tube);
  assign cp = 24'(smp_q.cos_ring);
  assign sp = 24'(smp_q.sin_ring);
  assign cx = tpzr_pkg::RingRad + ct;
  assign cy = st;

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (phase_q == tpzr_pkg::PH_PROJ) begin
      case (step_q)
        5'd0:    begin op_a = 24'({1'b0, dw_i[7:1]}); op_b = z_q; end
        5'd1:    begin op_a = 24'({1'b0, dw_i}); op_b = 24'(x_q <<< 1); end
        5'd2:    begin op_a = 24'({1'b0, h_i[6:1]}); op_b = z_q; end
        5'd3:    begin op_a = 24'({1'b0, dw_i}); op_b = y_q; end
        5'd4:    begin op_a = 24'({1'b0, dw_i}); op_b = z_q; end
        default: begin op_a = 24'({1'b0, h_i}); op_b = z_q; end
      endcase
    end else begin
      case (step_q)
        5'd0:    begin op_a = cb; op_b = cp; end
        5'd1:    begin op_a = sa; op_b = sb; end
        5'd2:    begin op_a = 24'(t_q[1]); op_b = sp; end
        5'd3:    begin op_a = cx; op_b = 24'(t_q[0] + t_q[2]); end
        5'd4:    begin op_a = ca; op_b = sb; end
        5'd5:    begin op_a = cy; op_b = 24'(t_q[4]); end
        5'd6:    begin op_a = sb; op_b = cp; end
        5'd7:    begin op_a = sa; op_b = cb; end
        5'd8:    begin op_a = 24'(t_q[7]); op_b = sp; end
        5'd9:    begin op_a = cx; op_b = 24'(t_q[6] - t_q[8]); end
        5'd10:   begin op_a = ca; op_b = cb; end
        5'd11:   begin op_a = cy; op_b = 24'(t_q[10]); end
        5'd12:   begin op_a = ca; op_b = cx; end
        5'd13:   begin op_a = 24'(t_q[12]); op_b = sp; end
        5'd14:   begin op_a = cy; op_b = sa; end
        5'd15:   begin op_a = cp; op_b = ct; end
        5'd16:   begin op_a = 24'(t_q[15]); op_b = sb; end
        5'd17:   begin op_a = ca; op_b = ct; end
        5'd18:   begin op_a = 24'(t_q[17]); op_b = sp; end
        5'd19:   begin op_a = sa; op_b = st; end
        5'd20:   begin op_a = ca; op_b = st; end
        5'd21:   begin op_a = ct; op_b = sa; end
        5'd22:   begin op_a = 24'(t_q[21]); op_b = sp; end
        5'd23:   begin op_a = cb; op_b = 24'(t_q[20] - t_q[22]); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  assign prod = op_a * op_b;
  assign numx = 33'(r_q[0]) + 33'(r_q[1]);
  assign numy = 33'(r_q[2]) - 33'(r_q[3]);
  assign negx = -34'(numx);
  assign negy = -34'(numy);

  always_comb begin
    div_start = 1'b0;
    div_rem   = 22'(numx >>> 7);
    div_bits  = {numx[6:0], 10'b0};
    div_steps = tpzr_pkg::CellDivSteps;
    case (phase_q)
      tpzr_pkg::PH_PROJ: begin
        div_start = (step_q == tpzr_pkg::NumProjSteps - 5'd1);
      end
      tpzr_pkg::PH_DIVX: begin
        div_start = div_done;
        div_rem   = 22'(numy >>> 7);
        div_bits  = {numy[6:0], 10'b0};
      end
      tpzr_pkg::PH_DIVY: begin
        div_start = div_done;
        div_rem   = tpzr_pkg::DepthDividend;
        div_bits  = '0;
        div_steps = tpzr_pkg::DepthDivSteps;
      end
      default: div_start = 1'b0;
    endcase
  end

  tpzr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .rem_i     (div_rem),
    .bits_i    (div_bits),
    .steps_i   (div_steps),
    .divisor_i (z_q[21:0]),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tpzr_pkg::PH_IDLE;
      step_q  <= '0;
    end else if (start_i) begin
      phase_q <= tpzr_pkg::PH_MUL;
      step_q  <= '0;
    end else begin
      case (phase_q)
        tpzr_pkg::PH_MUL: begin
          step_q <= step_q + 5'd1;
          if (step_q == tpzr_pkg::NumMulSteps - 5'd1) begin
            phase_q <= tpzr_pkg::PH_SUM;
          end
        end
        tpzr_pkg::PH_SUM: begin
          phase_q <= tpzr_pkg::PH_PROJ;
          step_q  <= '0;
        end
        tpzr_pkg::PH_PROJ: begin
          step_q <= step_q + 5'd1;
          if (step_q == tpzr_pkg::NumProjSteps - 5'd1) begin
            phase_q <= tpzr_pkg::PH_DIVX;
          end
        end
        tpzr_pkg::PH_DIVX: if (div_done) phase_q <= tpzr_pkg::PH_DIVY;
        tpzr_pkg::PH_DIVY: if (div_done) phase_q <= tpzr_pkg::PH_DIVZ;
        tpzr_pkg::PH_DIVZ: if (div_done) phase_q <= tpzr_pkg::PH_DONE;
        default: phase_q <= phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      smp_q <= sample_i;
    end
    if (phase_q == tpzr_pkg::PH_MUL) begin
      t_q[step_q] <= prod[39:14];
    end
    if (phase_q == tpzr_pkg::PH_SUM) begin
      x_q <= 24'(t_q[3] - t_q[5]);
      y_q <= 24'(t_q[9] + t_q[11]);
      z_q <= 24'(tpzr_pkg::ZBias + 24'(t_q[13]) + 24'(t_q[14]));
      l_q <= 24'(t_q[16] - t_q[18] - t_q[19] + t_q[23]);
    end
    if (phase_q == tpzr_pkg::PH_PROJ) begin
      r_q[step_q[2:0]] <= prod[31:0];
    end
    if (div_done && phase_q == tpzr_pkg::PH_DIVX) qx_q <= div_quot[6:0];
    if (div_done && phase_q == tpzr_pkg::PH_DIVY) qy_q <= div_quot[5:0];
    if (div_done && phase_q == tpzr_pkg::PH_DIVZ) ooz_q <= div_quot;
  end

  always_comb begin
    vx = (!numx[32] && 34'(numx) < 34'(r_q[4])) ||
         (numx[32] && negx < 34'(z_q) && dw_i != 8'd0);
    vy = (!numy[32] && 34'(numy) < 34'(r_q[5])) ||
         (numy[32] && negy < 34'(z_q) && h_i != 7'd0);
    hit_o.ok     = (z_q > 24'sd0) && vx && vy && (l_q > 24'sd0);
    hit_o.column = numx[32] ? '0 : qx_q;
    hit_o.row    = numy[32] ? '0 : qy_q;
    hit_o.glyph  = (l_q[23:11] > 13'(tpzr_pkg::GlyphMax)) ? tpzr_pkg::GlyphMax : l_q[14:11];
    hit_o.ooz    = (z_q <= tpzr_pkg::OozSatZ) ? tpzr_pkg::DepthMax : ooz_q;
  end

  assign done_o = (phase_q == tpzr_pkg::PH_DONE);
endmodule

/* design/torus_point_zbuffer_raster_unit.sv */
// Torus point z-buffer raster unit: one torus sample in, at most one plotted cell out.
// A sample is taken only once the previous one is through: 24 steps through one shared
// multiplier for the rotation and light, 1 for the sums, 6 more for the projection, then
// three divisions by the depth on one bit-per-cycle divider (7, 7 and 17 steps), and,
// for a hit, a read-compare-write of the depth RAM. After reset, and after every sample
// that starts a frame, the 8192-entry depth RAM is cleared one entry per cycle; no
// sample is taken until the clear is done, but the sample that starts the frame is
// computed meanwhile. A result waits in an output register while the next sample is
// taken; a plotted cell that finds the register still full waits until it drains.
module torus_point_zbuffer_raster_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpzr_in_if.sink     in_i,
  tpzr_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0] sw_q, dw;
  logic [6:0] sh_q, h;
  logic       cfg_wr;

  tpzr_pkg::state_e state_q, state_d;
  logic                       clr_act_q;
  logic [tpzr_pkg::AddrW-1:0] clr_addr_q, idx;
  logic                       accept, geom_done, commit, beats, rd_en, wr_en;
  logic [tpzr_pkg::AddrW-1:0] wr_addr;
  logic [tpzr_pkg::DepthW-1:0] wr_data, rd_data;
  tpzr_pkg::hit_t             hit;
  logic                       out_valid_q;
  tpzr_pkg::result_t          out_data_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == tpzr_pkg::RegScreenHeight) ? {25'b0, sh_q} : {24'b0, sw_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= 8'd110;
      sh_q <= 7'd40;
    end else if (cfg_wr) begin
      if (paddr[2] == tpzr_pkg::RegScreenWidth) begin
        sw_q <= pwdata[7:0];
      end else begin
        sh_q <= pwdata[6:0];
      end
    end
  end

  always_comb begin
    dw = (sw_q >= tpzr_pkg::WidthSplit) ? sw_q - tpzr_pkg::WidthMargin : sw_q;
    if (dw > 8'(tpzr_pkg::MaxWidth)) dw = 8'(tpzr_pkg::MaxWidth);
    h = (sh_q > 7'(tpzr_pkg::MaxHeight)) ? 7'(tpzr_pkg::MaxHeight) : sh_q;
  end

  assign in_i.ready = (state_q == tpzr_pkg::ST_IDLE) && !clr_act_q;
  assign accept     = in_i.valid && in_i.ready;

  tpzr_geom u_geom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .sample_i (in_i.data),
    .dw_i     (dw),
    .h_i      (h),
    .done_o   (geom_done),
    .hit_o    (hit)
  );

  assign idx   = {hit.row, hit.column};
  assign beats = hit.ooz > rd_data;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tpzr_pkg::ST_IDLE:  if (accept) state_d = tpzr_pkg::ST_BUSY;
      tpzr_pkg::ST_BUSY: begin
        if (geom_done && !clr_act_q) begin
          state_d = hit.ok ? tpzr_pkg::ST_READ : tpzr_pkg::ST_IDLE;
        end
      end
      tpzr_pkg::ST_READ:  state_d = tpzr_pkg::ST_CHECK;
      tpzr_pkg::ST_CHECK: begin
        if (!beats || !out_valid_q || out_o.ready) state_d = tpzr_pkg::ST_IDLE;
      end
      default: state_d = tpzr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en  = (state_q == tpzr_pkg::ST_READ);
    commit = (state_q == tpzr_pkg::ST_CHECK) && beats && (!out_valid_q || out_o.ready);
    wr_en   = clr_act_q || commit;
    wr_addr = clr_act_q ? clr_addr_q : idx;
    wr_data = clr_act_q ? '0 : hit.ooz;
  end

  tpzr_ram #(
    .Depth (tpzr_pkg::DepthCells),
    .Width (tpzr_pkg::DepthW)
  ) u_depth (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpzr_pkg::ST_IDLE;
      clr_act_q   <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_i.data.new_frame) begin
        clr_act_q  <= 1'b1;
        clr_addr_q <= '0;
      end else if (clr_act_q) begin
        clr_addr_q <= clr_addr_q + {{(tpzr_pkg::AddrW-1){1'b0}}, 1'b1};
        if (&clr_addr_q) clr_act_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_data_q.column <= hit.column;
      out_data_q.row    <= hit.row;
      out_data_q.glyph  <= hit.glyph;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_o.valid && out_o.data.glyph <= tpzr_pkg::GlyphMax)
    else $error("committed cell not presented");

  a_read_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tpzr_pkg::ST_READ |-> !clr_act_q && hit.ok)
    else $error("depth read during clear or without a hit");

  a_clear_full_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_act_q) |-> &$past(clr_addr_q))
    else $error("clear ended before the last entry");
endmodule

/* dv/tb_torus_point_zbuffer_raster_unit.sv */
// Self-checking testbench of the torus point z-buffer raster unit.
`timescale 1ns / 1ps
module tb_torus_point_zbuffer_raster_unit;

  localparam longint CycleLimit = 4000000;
  localparam int ClearWait = 9000;
  localparam int Q14One = 16384;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tpzr_in_if in_if ();
  tpzr_out_if out_if ();

  torus_point_zbuffer_raster_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_if.sink),
    .out_o(out_if.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  int unsigned depth_map [tpzr_pkg::DepthCells];
  logic [7:0] width_reg;
  logic [6:0] height_reg;
  tpzr_pkg::result_t cell_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int cells_seen = 0;
  longint cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 14;
  endfunction

  // Computes the plotted cell of one sample and updates the depth map.
  function automatic bit plot_cell(tpzr_pkg::sample_t s, output tpzr_pkg::result_t r);
    longint ca, sa, cb, sb, ct, st, cp, sp, cx, cy, x, y, z, lum, ooz, dw, h, xp, yp;
    int idx;
    longint g;
    ca = s.cos_a; sa = s.sin_a; cb = s.cos_b; sb = s.sin_b;
    ct = s.cos_tube; st = s.sin_tube; cp = s.cos_ring; sp = s.sin_ring;
    r = '0;
    if (s.new_frame) begin
      foreach (depth_map[i]) depth_map[i] = 0;
    end
    dw = longint'(width_reg) - 30;
    if (dw < 20) dw = width_reg;
    if (dw > tpzr_pkg::MaxWidth) dw = tpzr_pkg::MaxWidth;
    h = height_reg;
    if (h > tpzr_pkg::MaxHeight) h = tpzr_pkg::MaxHeight;
    cx = 2 * Q14One + ct;
    cy = st;
    x = qmul(cx, qmul(cb, cp) + qmul(qmul(sa, sb), sp)) - qmul(cy, qmul(ca, sb));
    y = qmul(cx, qmul(sb, cp) - qmul(qmul(sa, cb), sp)) + qmul(cy, qmul(ca, cb));
    z = 16 * Q14One + qmul(qmul(ca, cx), sp) + qmul(cy, sa);
    lum = qmul(qmul(cp, ct), sb) - qmul(qmul(ca, ct), sp) - qmul(sa, st)
        + qmul(cb, qmul(ca, st) - qmul(qmul(ct, sa), sp));
    if (z <= 0) return 0;
    ooz = (64'sd1 <<< 34) / z;
    if (ooz > 131071) ooz = 131071;
    xp = ((dw / 2) * z + 2 * dw * x) / z;
    yp = ((h / 2) * z - dw * y) / z;
    if (xp < 0 || xp >= dw || yp < 0 || yp >= h) return 0;
    idx = int'(xp + yp * tpzr_pkg::MaxWidth);
    if (lum <= 0 || ooz <= depth_map[idx]) return 0;
    depth_map[idx] = int'(ooz);
    g = lum >>> 11;
    if (g > 11) g = 11;
    r.column = xp[6:0];
    r.row = yp[5:0];
    r.glyph = g[3:0];
    return 1;
  endfunction

  always @(posedge clk_i) begin
    tpzr_pkg::result_t want;
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (out_if.valid && out_if.ready) begin
      cells_seen++;
      if (cell_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected cell col %0d row %0d glyph %0d", $time,
                 out_if.data.column, out_if.data.row, out_if.data.glyph);
      end else begin
        want = cell_q.pop_front();
        if (want.column !== out_if.data.column) begin
          errors++;
          $display("%0t: column expected %0d actual %0d", $time, want.column,
                   out_if.data.column);
        end
        if (want.row !== out_if.data.row) begin
          errors++;
          $display("%0t: row expected %0d actual %0d", $time, want.row, out_if.data.row);
        end
        if (want.glyph !== out_if.data.glyph) begin
          errors++;
          $display("%0t: glyph expected %0d actual %0d", $time, want.glyph,
                   out_if.data.glyph);
        end
      end
    end
  end

  task automatic send_sample(tpzr_pkg::sample_t s);
    tpzr_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    if (plot_cell(s, r)) cell_q = {cell_q, r};
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (cell_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    logic [31:0] mask;
    drain();
    repeat (ClearWait) @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == tpzr_pkg::RegScreenWidth) width_reg = value[7:0];
    else height_reg = value[6:0];
    mask = (idx == tpzr_pkg::RegScreenWidth) ? 32'hFF : 32'h7F;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if ((prdata & mask) !== (value & mask)) begin
      errors++;
      $display("%0t: register %0d readback expected %0d actual %0d", $time, idx,
               value & mask, prdata & mask);
    end
  endtask

  function automatic logic signed [15:0] q14(real v);
    return 16'($rtoi(v * Q14One));
  endfunction

  function automatic tpzr_pkg::sample_t torus_sample(bit nf, real a, real b, real t, real p);
    tpzr_pkg::sample_t s;
    s.new_frame = nf;
    s.cos_a = q14($cos(a)); s.sin_a = q14($sin(a));
    s.cos_b = q14($cos(b)); s.sin_b = q14($sin(b));
    s.cos_tube = q14($cos(t)); s.sin_tube = q14($sin(t));
    s.cos_ring = q14($cos(p)); s.sin_ring = q14($sin(p));
    return s;
  endfunction

  function automatic real rand_angle();
    return $urandom_range(62831) / 10000.0;
  endfunction

  task automatic test_directed();
    tpzr_pkg::sample_t s;
    s = '0;
    send_sample(s);
    s = '{1'b0, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384};
    send_sample(s);
    s = '{1'b0, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384};
    send_sample(s);
    s = '{1'b0, -32768, 32767, 0, 0, 32767, -32768, 0, 32767};
    send_sample(s);
    s = '{1'b1, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    send_sample(s);
    s = '{1'b0, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_sample(s);
    s = torus_sample(1'b0, 0.0, 0.0, 0.0, 0.0);
    send_sample(s);
    s = torus_sample(1'b0, 1.0, 0.5, 5.5, 0.3);
    send_sample(s);
    send_sample(s);
    s.new_frame = 1'b1;
    send_sample(s);
    send_sample(s);
    for (int i = 0; i < 6; i++) begin
      s = torus_sample(1'b0, 0.7, 1.2, 0.9 * i, 1.1 * i);
      send_sample(s);
    end
    drain();
    for (int i = 0; i < 4; i++) begin
      s = torus_sample(1'b0, 0.4 * i, 0.3, 1.5 * i, 2.0 * i);
      send_sample(s);
    end
  endtask

  task automatic test_random(int count);
    tpzr_pkg::sample_t s;
    real a, b;
    a = rand_angle();
    b = rand_angle();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        s = tpzr_pkg::sample_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        s.new_frame = ($urandom_range(19) == 0);
      end else begin
        s = torus_sample(1'b0, a, b, rand_angle(), rand_angle());
        if ($urandom_range(99) == 0) begin
          a = rand_angle();
          b = rand_angle();
          s = torus_sample(1'b1, a, b, rand_angle(), rand_angle());
        end
      end
      send_sample(s);
      if ($urandom_range(9) == 0) send_sample(s);
    end
  endtask

  initial begin
    width_reg = 8'd110;
    height_reg = 7'd40;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(tpzr_pkg::RegScreenWidth, 32'd158);
    write_reg(tpzr_pkg::RegScreenHeight, 32'd64);
    test_directed();
    write_reg(tpzr_pkg::RegScreenWidth, 32'd1);
    write_reg(tpzr_pkg::RegScreenHeight, 32'd1);
    test_directed();
    write_reg(tpzr_pkg::RegScreenWidth, 32'd0);
    write_reg(tpzr_pkg::RegScreenHeight, 32'd0);
    test_random(20);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 48 : 0;
      recv_stall_pct = (ph == 0) ? 48 : (ph == 1) ? 24 : 0;
      write_reg(tpzr_pkg::RegScreenWidth,
                (ph == 0) ? 32'd110 : (ph == 1) ? 32'd50 : 32'd49);
      write_reg(tpzr_pkg::RegScreenHeight,
                (ph == 0) ? 32'd40 : (ph == 1) ? 32'd127 : 32'd63);
      test_random(300);
      write_reg(tpzr_pkg::RegScreenWidth,
                (ph == 0) ? 32'd20 : (ph == 1) ? 32'd255 : 32'd51);
      write_reg(tpzr_pkg::RegScreenHeight,
                (ph == 0) ? 32'd17 : (ph == 1) ? 32'd64 : 32'd2);
      test_random(270);
    end
    drain();
    repeat (ClearWait) @(posedge clk_i);
    $display("Sent %0d samples over several screen sizes and handshake mixes;", items_sent);
    $display("checked %0d plotted cells against the predicted depth-tested cells.", cells_seen);
    if (errors == 0 && cell_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
